// ===== hw/rtl/cpct_pkg.sv =====
// ============================================================================
// Collider pair contact tracker package
// Shared constants, event codes and controller/datapath command types.
// ============================================================================
package cpct_pkg;

   localparam int POS_BITS  = 20;
   localparam int SIZE_BITS = 12;
   // A half size scaled by 100 is size*50, at most 204750, which needs 18 bits.
   localparam int HALF_BITS = 18;
   // Working width for coordinates and differences.
   localparam int WIDE_BITS = 23;
   localparam int SQ_BITS   = 48;
   localparam int HALF_SCALE = 50;

   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_ENTER = 2'd1;
   localparam logic [1:0] EV_STAY  = 2'd2;
   localparam logic [1:0] EV_EXIT  = 2'd3;

   typedef struct packed {
      logic load;
      logic decide;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } stat_type;

endpackage

// ===== hw/rtl/cpct_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module cpct_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cpct_ctrl.sv =====
// ============================================================================
// Contact tracker controller
// Clears the pair table after reset, then sequences load and decide cycles.
// ============================================================================
module cpct_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  cpct_pkg::stat_type  stat,
   output cpct_pkg::cmd_type   cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

// ===== hw/rtl/cpct_dp.sv =====
// ============================================================================
// Contact tracker datapath
// Overlap geometry, pair table access and event generation.
// ============================================================================
module cpct_dp #(
   parameter int ID_BITS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cpct_pkg::cmd_type         cmd,
   output cpct_pkg::stat_type        stat,
   input  logic [ID_BITS-1:0]        first_id,
   input  logic [ID_BITS-1:0]        second_id,
   input  logic                      first_shape,
   input  logic signed [19:0]        first_x,
   input  logic signed [19:0]        first_y,
   input  logic [11:0]               first_w,
   input  logic [11:0]               first_h,
   input  logic                      second_shape,
   input  logic signed [19:0]        second_x,
   input  logic signed [19:0]        second_y,
   input  logic [11:0]               second_w,
   input  logic [11:0]               second_h,
   output logic [1:0]                contact_event,
   output logic                      overlapping
);

   localparam int AB = 2 * ID_BITS;
   localparam int WB = cpct_pkg::WIDE_BITS;
   localparam int SB = cpct_pkg::SQ_BITS;
   localparam int HB = cpct_pkg::HALF_BITS;

   typedef logic signed [WB-1:0] wide_type;
   typedef logic signed [SB-1:0] sq_type;

   wide_type x1, y1, x2, y2, w1, h1, w2, h2;
   wide_type cx, cy, rr, rx, ry, hx, hy, px, py, dx, dy;
   wide_type adx, ady;
   logic     rect_hit;
   logic     c1, c2;

   always_comb begin
      x1 = WB'(first_x);
      y1 = WB'(first_y);
      x2 = WB'(second_x);
      y2 = WB'(second_y);
      w1 = WB'($signed({1'b0, HB'(first_w * cpct_pkg::HALF_SCALE)}));
      h1 = WB'($signed({1'b0, HB'(first_h * cpct_pkg::HALF_SCALE)}));
      w2 = WB'($signed({1'b0, HB'(second_w * cpct_pkg::HALF_SCALE)}));
      h2 = WB'($signed({1'b0, HB'(second_h * cpct_pkg::HALF_SCALE)}));
      c1 = first_shape;
      c2 = second_shape;
      adx = (x1 > x2) ? x1 - x2 : x2 - x1;
      ady = (y1 > y2) ? y1 - y2 : y2 - y1;
      rect_hit = (adx < w1 + w2) && (ady < h1 + h2);
      if (c1) begin
         cx = x1 + w1; cy = y1 + h1; rr = w1;
         rx = x2; ry = y2; hx = w2; hy = h2;
      end else begin
         cx = x2 + w2; cy = y2 + h2; rr = w2;
         rx = x1; ry = y1; hx = w1; hy = h1;
      end
      if (c1 && c2) begin
         dx = (x1 + w1) - (x2 + w2);
         dy = (y1 + h1) - (y2 + h2);
         rr = w1 + w2;
         px = '0;
         py = '0;
      end else begin
         px = (cx < rx - hx) ? rx - hx : ((cx > rx + hx) ? rx + hx : cx);
         py = (cy < ry - hy) ? ry - hy : ((cy > ry + hy) ? ry + hy : cy);
         dx = cx - px;
         dy = cy - py;
      end
   end

   // First cycle: register the squares and the table read.
   sq_type dx2_ff, dy2_ff, r2_ff;
   logic   rect_ff, cc_ff, rr_mode_ff;
   logic [AB-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dx2_ff     <= SB'(dx * dx);
         dy2_ff     <= SB'(dy * dy);
         r2_ff      <= SB'(rr * rr);
         rect_ff    <= rect_hit;
         cc_ff      <= c1 && c2;
         rr_mode_ff <= !c1 && !c2;
         idx_ff     <= {first_id, second_id};
      end
   end

   logic [AB-1:0] clr_ff, clr_in;
   logic          hit, touching, wr_en, wr_data;
   logic [AB-1:0] wr_addr;
   logic [1:0]    ev_ff, ev_in;
   logic          ov_ff;
   sq_type        sum;

   always_comb begin
      sum = dx2_ff + dy2_ff;
      if (rr_mode_ff) hit = rect_ff;
      else if (cc_ff) hit = sum <= r2_ff;
      else hit = sum < r2_ff;
      ev_in = hit ? (touching ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER)
                  : (touching ? cpct_pkg::EV_EXIT : cpct_pkg::EV_NONE);
      clr_in = clr_ff + AB'(1);
      if (cmd.clear) begin
         wr_en = 1'b1; wr_addr = clr_ff; wr_data = 1'b0;
      end else begin
         wr_en = cmd.decide; wr_addr = idx_ff; wr_data = hit;
      end
   end

   cpct_ram #(.WIDTH(1), .DEPTH(1 << AB)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({first_id, second_id}),
      .rd_data (touching)
   );

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_in;
      if (cmd.decide) begin
         ev_ff <= ev_in;
         ov_ff <= hit;
      end
   end

   assign stat.clear_done = &clr_ff;
   assign contact_event   = ev_ff;
   assign overlapping     = ov_ff;

endmodule

// ===== hw/rtl/collider_pair_contact_tracker.sv =====
// ============================================================================
// Collider pair contact tracker
// Tests one collider pair for overlap and reports enter, stay or exit events.
// ============================================================================
//  channel  ports   direction  contents
//  req      req_*   in         collider pair: IDs, shapes, positions, sizes
//  rsp      rsp_*   out        contact event and overlap flag
//
//  Each word is handled in a load step for geometry, squares and table read,
//  then a decide step for the compare and table write. A new word is taken as the result leaves.
//  After reset the pair table is cleared, one entry a cycle, while req_ready
//  stays low.
//  A stalled result holds the block until rsp_ready rises.
module collider_pair_contact_tracker #(
   parameter int ID_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ID_BITS-1:0]  req_first_id,
   input  logic [ID_BITS-1:0]  req_second_id,
   input  logic                req_first_shape,
   input  logic signed [19:0]  req_first_x,
   input  logic signed [19:0]  req_first_y,
   input  logic [11:0]         req_first_w,
   input  logic [11:0]         req_first_h,
   input  logic                req_second_shape,
   input  logic signed [19:0]  req_second_x,
   input  logic signed [19:0]  req_second_y,
   input  logic [11:0]         req_second_w,
   input  logic [11:0]         req_second_h,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_contact_event,
   output logic                rsp_overlapping
);

   cpct_pkg::cmd_type  cmd;
   cpct_pkg::stat_type stat;

   cpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpct_dp #(.ID_BITS(ID_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .first_id      (req_first_id),
      .second_id     (req_second_id),
      .first_shape   (req_first_shape),
      .first_x       (req_first_x),
      .first_y       (req_first_y),
      .first_w       (req_first_w),
      .first_h       (req_first_h),
      .second_shape  (req_second_shape),
      .second_x      (req_second_x),
      .second_y      (req_second_y),
      .second_w      (req_second_w),
      .second_h      (req_second_h),
      .contact_event (rsp_contact_event),
      .overlapping   (rsp_overlapping)
   );

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_ready && req_valid) else $error("load without accept");
   a_decide_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.decide) else $error("decide did not follow load");
   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_valid) else $error("no result after decide");
   a_ov_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_overlapping == (rsp_contact_event == cpct_pkg::EV_ENTER
         || rsp_contact_event == cpct_pkg::EV_STAY))) else $error("event mismatch");

endmodule

// ===== verif/collider_pair_contact_tracker_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Collider pair contact tracker testbench
// Drives collider pairs with random idling on both channels, predicts the
// overlap test and the pair table in a scoreboard class, and checks every
// result word field by field in order.
// ============================================================================
module collider_pair_contact_tracker_tb;

   class contact_scoreboard;
      bit touching [4096];
      logic [1:0] ev_q [$];
      logic       hit_q [$];
      int mismatches;
      int checked;
      int enters;
      int exits;

      function longint clampv(longint v, longint lo, longint hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function bit circ_rect(longint cx, longint cy, longint r, longint rx, longint ry,
                             longint hx, longint hy);
         longint dx;
         longint dy;
         dx = cx - clampv(cx, rx - hx, rx + hx);
         dy = cy - clampv(cy, ry - hy, ry + hy);
         return dx * dx + dy * dy < r * r;
      endfunction

      function void note_pair(logic [5:0] a, logic [5:0] b, bit c1, logic signed [19:0] x1r,
                              logic signed [19:0] y1r, logic [11:0] w1r, logic [11:0] h1r,
                              bit c2, logic signed [19:0] x2r, logic signed [19:0] y2r,
                              logic [11:0] w2r, logic [11:0] h2r);
         longint x1;
         longint y1;
         longint w1;
         longint h1;
         longint x2;
         longint y2;
         longint w2;
         longint h2;
         longint dx;
         longint dy;
         bit hit;
         logic [1:0] ev;
         int idx;
         x1 = x1r; y1 = y1r; w1 = w1r * 50; h1 = h1r * 50;
         x2 = x2r; y2 = y2r; w2 = w2r * 50; h2 = h2r * 50;
         if (!c1 && !c2) begin
            dx = x1 - x2; dy = y1 - y2;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            hit = dx < w1 + w2 && dy < h1 + h2;
         end else if (c1 && c2) begin
            dx = (x1 + w1) - (x2 + w2);
            dy = (y1 + h1) - (y2 + h2);
            hit = dx * dx + dy * dy <= (w1 + w2) * (w1 + w2);
         end else if (c1) begin
            hit = circ_rect(x1 + w1, y1 + h1, w1, x2, y2, w2, h2);
         end else begin
            hit = circ_rect(x2 + w2, y2 + h2, w2, x1, y1, w1, h1);
         end
         idx = {a, b};
         if (hit) begin
            ev = touching[idx] ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
            touching[idx] = 1;
         end else if (touching[idx]) begin
            ev = cpct_pkg::EV_EXIT;
            touching[idx] = 0;
         end else begin
            ev = cpct_pkg::EV_NONE;
         end
         ev_q.push_back(ev);
         hit_q.push_back(hit);
      endfunction

      function void check_result(logic [1:0] ev, logic hit);
         logic [1:0] e_ev;
         logic e_hit;
         if (ev_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result word: event %0d overlap %0d", ev, hit);
            return;
         end
         e_ev = ev_q.pop_front();
         e_hit = hit_q.pop_front();
         checked++;
         if (e_ev == cpct_pkg::EV_ENTER) enters++;
         if (e_ev == cpct_pkg::EV_EXIT) exits++;
         if (ev !== e_ev || hit !== e_hit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch on word %0d: event exp %0d got %0d, overlap exp %0d got %0d",
                        checked, e_ev, ev, e_hit, hit);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [5:0] req_first_id = 0;
   logic [5:0] req_second_id = 0;
   logic req_first_shape = 0;
   logic signed [19:0] req_first_x = 0;
   logic signed [19:0] req_first_y = 0;
   logic [11:0] req_first_w = 0;
   logic [11:0] req_first_h = 0;
   logic req_second_shape = 0;
   logic signed [19:0] req_second_x = 0;
   logic signed [19:0] req_second_y = 0;
   logic [11:0] req_second_w = 0;
   logic [11:0] req_second_h = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_contact_event;
   logic rsp_overlapping;

   contact_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int cycles = 0;
   int sent = 0;

   always #10 clock = ~clock;

   collider_pair_contact_tracker #(.ID_BITS(6)) dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 800000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_contact_event, rsp_overlapping);

   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_pair(logic [5:0] a, logic [5:0] b, bit c1, logic [19:0] x1,
                            logic [19:0] y1, logic [11:0] w1, logic [11:0] h1, bit c2,
                            logic [19:0] x2, logic [19:0] y2, logic [11:0] w2,
                            logic [11:0] h2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_first_id <= a; req_second_id <= b;
      req_first_shape <= c1; req_first_x <= x1; req_first_y <= y1;
      req_first_w <= w1; req_first_h <= h1;
      req_second_shape <= c2; req_second_x <= x2; req_second_y <= y2;
      req_second_w <= w2; req_second_h <= h2;
      do @(posedge clock); while (!req_ready);
      board.note_pair(a, b, c1, x1, y1, w1, h1, c2, x2, y2, w2, h2);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random(bit near);
      logic [5:0] a;
      logic [5:0] b;
      logic [19:0] x1;
      logic [19:0] y1;
      logic [19:0] x2;
      logic [19:0] y2;
      a = 6'($urandom_range(7));
      b = 6'($urandom_range(7));
      if ($urandom_range(9) == 0) begin
         a = 6'($urandom); b = 6'($urandom);
      end
      x1 = 20'($urandom); y1 = 20'($urandom);
      if (near) begin
         x2 = x1 + 20'($signed($urandom_range(400000)) - 200000);
         y2 = y1 + 20'($signed($urandom_range(400000)) - 200000);
      end else begin
         x2 = 20'($urandom); y2 = 20'($urandom);
      end
      send_pair(a, b, 1'($urandom), x1, y1, 12'($urandom), 12'($urandom), 1'($urandom),
                x2, y2, 12'($urandom), 12'($urandom));
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.ev_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      recv_stall_pct = 0;
      send_pair(0, 0, 0, 0, 0, 12'hfff, 12'hfff, 0, 0, 0, 12'hfff, 12'hfff);
      send_pair(0, 0, 0, 0, 0, 12'hfff, 12'hfff, 0, 0, 0, 12'hfff, 12'hfff);
      send_pair(0, 0, 0, 20'h7ffff, 20'h7ffff, 0, 0, 0, 20'h80000, 20'h80000, 0, 0);
      send_pair(1, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(3, 3, 1, 5, 5, 0, 0, 1, 5, 5, 0, 0);
      send_pair(3, 3, 1, 5, 5, 0, 0, 1, 6, 5, 0, 0);
      send_pair(2, 1, 1, 0, 0, 10, 10, 0, 1000, 1000, 10, 10);
      send_pair(1, 2, 0, 1000, 1000, 10, 10, 1, 0, 0, 10, 10);
      send_pair(63, 63, 1, 20'h80000, 20'h7ffff, 12'hfff, 0, 1, 20'h7ffff, 20'h80000,
                12'hfff, 12'hfff);
      send_pair(63, 0, 1, 0, 0, 100, 100, 0, 5000, 5000, 1, 1);
      send_pair(63, 0, 1, 0, 0, 100, 100, 0, 500000, 0, 1, 1);
      send_pair(0, 63, 0, 100, 0, 2, 2, 0, 199, 0, 0, 0);
      send_pair(0, 63, 0, 100, 0, 2, 2, 0, 200, 0, 0, 0);
      send_pair(5, 6, 1, 20'hfffff, 20'hfffff, 1, 1, 1, 0, 0, 1, 1);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 76 : (phase == 3) ? 33 : 0;
         recv_stall_pct = (phase == 2) ? 76 : (phase == 3) ? 33 : 0;
         if (phase == 0) hold_off = 300;
         for (int i = 0; i < 460; i++) send_random($urandom_range(9) < 8);
         drain();
      end
      $display("Ran %0d collider pairs, %0d results checked, %0d enters and %0d exits.",
               sent, board.checked, board.enters, board.exits);
      if (board.mismatches == 0 && board.ev_q.size() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule
